[src/ring_buffer_deque_top_assert.svh]
// Assertion helpers; clocked on clk_i, disabled while rst_ni is low.
`ifndef RING_BUFFER_DEQUE_TOP_ASSERT_SVH
`define RING_BUFFER_DEQUE_TOP_ASSERT_SVH

// Property that must hold at every edge (may itself contain |->).
`define RBD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RBD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rbd_pkg.sv]
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned WORD_BITS = 32;

  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CAP_FLD_W = 7;
  localparam int unsigned APB_W     = 32;
  localparam int unsigned PADDR_W   = 2;
  // stored bits: the result field carries at most DATA_W of them
  localparam int unsigned KEEP_W    = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;

  // byte address of the capacity register
  localparam logic [PADDR_W-1:0] CAP_ADDR = '0;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_BACK   = 3'd0,
    OP_ADD_FRONT  = 3'd1,
    OP_TAKE_FRONT = 3'd2,
    OP_TAKE_BACK  = 3'd3,
    OP_DUMP       = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DATA      = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_EMPTY     = 2'd3
  } stat_e;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
    logic              last;
  } out_word_t;

  // capacity register toward the controller
  typedef struct packed {
    logic             clear;
    logic [CNT_W-1:0] capacity;
  } cfg_t;

  // one write port and one read port of the entry store
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [KEEP_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage

[src/rbd_ram.sv]
`timescale 1ns / 1ps

module rbd_ram #(
  parameter int unsigned DEPTH_P = 64,
  parameter int unsigned WIDTH_P = 32
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH_P)-1:0] waddr_i,
  input  logic [WIDTH_P-1:0]         wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH_P)-1:0] raddr_i,
  output logic [WIDTH_P-1:0]         rdata_o
);

  logic [WIDTH_P-1:0] mem_q [DEPTH_P];
  logic [WIDTH_P-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/rbd_ctrl.sv]
`timescale 1ns / 1ps
`include "ring_buffer_deque_top_assert.svh"

module rbd_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rbd_pkg::cfg_t            cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  rbd_pkg::in_word_t        in_word_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output rbd_pkg::out_word_t       out_word_o,
  output rbd_pkg::mem_req_t        mem_req_o,
  input  logic [rbd_pkg::KEEP_W-1:0] mem_rdata_i
);

  import rbd_pkg::*;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] nxt;
    nxt = CNT_W'(idx) + CNT_W'(1);
    idx_inc = (nxt >= cap) ? '0 : nxt[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] top;
    top = cap - CNT_W'(1);
    idx_dec = (idx == '0) ? top[IDX_W-1:0] : idx - IDX_W'(1);
  endfunction

  state_e           state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [IDX_W-1:0] back_q, back_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [IDX_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] rd_left_q, rd_left_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, out_d;

  op_e              op;
  logic             slot_free;
  logic             accept;
  logic             full;
  logic             empty;
  logic             is_push;
  logic             push_ok;
  logic [IDX_W-1:0] new_idx;

  assign op        = op_e'(in_word_i.opcode);
  assign slot_free = !out_valid_q || out_ready_i;
  assign full      = occ_q >= cfg_i.capacity;
  assign empty     = occ_q == '0;
  assign is_push   = (op == OP_ADD_BACK) || (op == OP_ADD_FRONT);
  assign push_ok   = accept && is_push && !full && !cfg_i.clear;

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    back_d      = back_q;
    occ_d       = occ_q;
    rd_ptr_d    = rd_ptr_q;
    rd_left_d   = rd_left_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_req_o   = '0;
    new_idx     = '0;
    in_ready_o  = 1'b0;
    accept      = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = slot_free;
        accept     = in_valid_i && slot_free;
        if (accept) begin
          case (op)
            OP_ADD_BACK, OP_ADD_FRONT: begin
              if (full) begin
                out_valid_d = 1'b1;
                out_d       = '{status: STAT_OVERFLOW, data: '0, last: 1'b1};
              end else begin
                if (op == OP_ADD_BACK) begin
                  new_idx = empty ? back_q : idx_inc(back_q, cfg_i.capacity);
                  back_d  = new_idx;
                end else begin
                  new_idx = empty ? front_q : idx_dec(front_q, cfg_i.capacity);
                  front_d = new_idx;
                end
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = new_idx;
                mem_req_o.wdata = in_word_i.value[KEEP_W-1:0];
                occ_d           = occ_q + CNT_W'(1);
              end
            end
            OP_TAKE_FRONT, OP_TAKE_BACK: begin
              if (empty) begin
                out_valid_d = 1'b1;
                out_d       = '{status: STAT_UNDERFLOW, data: '0, last: 1'b1};
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = (op == OP_TAKE_FRONT) ? front_q : back_q;
                occ_d           = occ_q - CNT_W'(1);
                if (occ_q == CNT_W'(1)) begin
                  front_d = '0;
                  back_d  = '0;
                end else if (op == OP_TAKE_FRONT) begin
                  front_d = idx_inc(front_q, cfg_i.capacity);
                end else begin
                  back_d = idx_dec(back_q, cfg_i.capacity);
                end
                rd_left_d = '0;
                state_d   = S_READ;
              end
            end
            OP_DUMP: begin
              if (empty) begin
                out_valid_d = 1'b1;
                out_d       = '{status: STAT_EMPTY, data: '0, last: 1'b1};
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = front_q;
                rd_ptr_d        = idx_inc(front_q, cfg_i.capacity);
                rd_left_d       = occ_q - CNT_W'(1);
                state_d         = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        // read data waits in the RAM output until the result slot frees
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{status: STAT_DATA, data: DATA_W'(mem_rdata_i),
                          last: (rd_left_q == '0)};
          if (rd_left_q != '0) begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = rd_ptr_q;
            rd_ptr_d        = idx_inc(rd_ptr_q, cfg_i.capacity);
            rd_left_d       = rd_left_q - CNT_W'(1);
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_i.clear) begin
      front_d = '0;
      back_d  = '0;
      occ_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      back_q      <= '0;
      occ_q       <= '0;
      rd_ptr_q    <= '0;
      rd_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      back_q      <= back_d;
      occ_q       <= occ_d;
      rd_ptr_q    <= rd_ptr_d;
      rd_left_q   <= rd_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `RBD_ASSERT(a_occ_le_cap, occ_q <= cfg_i.capacity, "occupancy above capacity")
  `RBD_ASSERT(a_empty_idx, empty |-> (front_q == '0 && back_q == '0), "index moved while empty")
  `RBD_ASSERT(a_dump_tail, (out_valid_q && !out_q.last) |-> (state_q == S_READ), "stray word")
  `RBD_ASSERT_NEXT(a_push_grows, push_ok, occ_q == $past(occ_q) + CNT_W'(1), "push lost")

endmodule

[src/ring_buffer_deque_top.sv]
// Deque of words in a single-port-write, single-port-read synchronous RAM.
// Push: no result; one push per cycle while the result slot is free. Overflow/underflow/empty
// status: one registered result, visible the cycle after acceptance; next item may enter then.
// Pop: the word passes the RAM read register, then the result register; no item enters meanwhile.
// Dump of n words: one word per cycle while out_ready_i stays high.
// Reset: queue empty, indices 0, capacity 64; RAM contents are not cleared.
`timescale 1ns / 1ps

module ring_buffer_deque_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // item channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rbd_pkg::in_word_t               in_word_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rbd_pkg::out_word_t              out_word_o,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbd_pkg::PADDR_W-1:0]     paddr,
  input  logic [rbd_pkg::APB_W-1:0]       pwdata,
  output logic [rbd_pkg::APB_W-1:0]       prdata,
  output logic                            pready
);

  import rbd_pkg::*;

  logic [CNT_W-1:0]     cap_q, cap_d;
  logic [CAP_FLD_W-1:0] cap_wr;
  logic                 cfg_wr;
  cfg_t                 cfg;
  mem_req_t             mem_req;
  logic [KEEP_W-1:0]    mem_rdata;

  // Single register: capacity sits at byte address 0, so every write offset
  // in the 4-byte window decodes to it; reads off that address return zero.
  // Zero-wait port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cap_wr = pwdata[CAP_FLD_W-1:0];

  // Clamp the written capacity into 1..DEPTH.
  always_comb begin
    cap_d = cap_q;
    if (cfg_wr) begin
      if (cap_wr == '0) begin
        cap_d = CNT_W'(1);
      end else if (32'(cap_wr) > DEPTH) begin
        cap_d = CNT_W'(DEPTH);
      end else begin
        cap_d = CNT_W'(cap_wr);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CNT_W'(DEPTH);
    end else begin
      cap_q <= cap_d;
    end
  end

  assign prdata = (paddr == CAP_ADDR) ? APB_W'(cap_q) : '0;

  // Controller sees the write strobe while the capacity is still the old value,
  // so the queue empties at the same edge that loads the new capacity.
  assign cfg.clear    = cfg_wr;
  assign cfg.capacity = cap_q;

  rbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Entry store: one write and one read per cycle, registered read data.
  // Only one item is handled per cycle, so a read never meets a write to
  // the same entry in the same cycle.
  rbd_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (KEEP_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule
